### src/jms_pkg.sv
// jms_pkg: shared types, constants and helpers for the JPEG marker segmenter.
// Used by the parser, the result queue and the top level; depends on nothing.
package jms_pkg;

   localparam int OFFSET_BITS_DEF = 32;

   localparam logic [7:0]  BYTE_FF    = 8'hFF;
   localparam logic [7:0]  BYTE_STUFF = 8'h00;
   localparam logic [7:0]  RST_FIRST  = 8'hD0;
   localparam logic [7:0]  RST_LAST   = 8'hD7;
   localparam logic [15:0] MARKER_SOI = 16'hFFD8;
   localparam logic [15:0] MARKER_EOI = 16'hFFD9;

   // One segment record as it leaves the block.
   typedef struct packed {
      logic [31:0] segment_offset;
      logic [31:0] segment_size;
      logic [15:0] marker_code;
      logic        truncated;
      logic        last_of_run;
   } rec_type;

   // Records produced by one accepted byte; rec_b is used only when count is 2.
   typedef struct packed {
      logic [1:0] count;
      rec_type    rec_a;
      rec_type    rec_b;
   } push_type;

   // Saturate a wide offset or size to 32 bits.
   function automatic logic [31:0] clamp32(logic [63:0] x);
      return (x[63:32] != 32'h0) ? 32'hFFFF_FFFF : x[31:0];
   endfunction

   function automatic rec_type make_rec(logic [63:0] start, logic [63:0] size,
                                        logic [15:0] marker, logic trunc);
      rec_type r;
      r.segment_offset = clamp32(start);
      r.segment_size   = clamp32(size);
      r.marker_code    = marker;
      r.truncated      = trunc;
      r.last_of_run    = 1'b0;
      return r;
   endfunction

   function automatic logic is_soi_eoi(logic [15:0] w);
      return (w == MARKER_SOI) || (w == MARKER_EOI);
   endfunction

endpackage

### src/jms_req_if.sv
// jms_req_if: valid/ready channel carrying one file byte per word.
// Stand-alone; no package dependency.
interface jms_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_data;

   modport source (output valid, output data_byte, output end_of_data, input ready);
   modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

### src/jms_rsp_if.sv
// jms_rsp_if: valid/ready channel carrying one segment record per word.
// Stand-alone; no package dependency.
interface jms_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] segment_offset;
   logic [31:0] segment_size;
   logic [15:0] marker_code;
   logic        truncated;
   logic        last_of_run;

   modport source (output valid, output segment_offset, output segment_size,
                   output marker_code, output truncated, output last_of_run,
                   input ready);
   modport sink   (input valid, input segment_offset, input segment_size,
                   input marker_code, input truncated, input last_of_run,
                   output ready);
endinterface

### src/jms_parser.sv
// jms_parser: per-byte marker/segment state machine; emits up to two records.
// Depends on jms_pkg.
module jms_parser #(
   parameter int OFFSET_BITS = jms_pkg::OFFSET_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept_i,
   input  logic [7:0]         data_byte_i,
   input  logic               end_of_data_i,
   output jms_pkg::push_type  push_o
);

   typedef enum logic [6:0] {
      PH_M1      = 7'b0000001,
      PH_M2      = 7'b0000010,
      PH_LEN_HI  = 7'b0000100,
      PH_LEN_LO  = 7'b0001000,
      PH_PAYLOAD = 7'b0010000,
      PH_SCAN    = 7'b0100000,
      PH_SCAN_FF = 7'b1000000
   } phase_type;

   localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
   localparam logic [OFFSET_BITS-1:0] OFF_ONE = OFFSET_BITS'(1);

   phase_type              phase_ff, phase_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;      // offset of the incoming byte
   logic [OFFSET_BITS-1:0] pos1_ff, pos1_in;    // saturated pos + 1
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [15:0]            marker_ff, marker_in;
   logic [16:0]            hdr_ff, hdr_in;
   logic [16:0]            skip_ff, skip_in;

   logic [OFFSET_BITS-1:0] seen, ffpos, close_size, seen2;
   logic [15:0]            len;
   logic [16:0]            hdr_len;
   logic [16:0]            skip_dec;
   logic [15:0]            new_marker;
   logic                   emit_a, emit_b;
   jms_pkg::rec_type       rec_a, rec_b;

   assign seen       = (pos1_ff > start_ff) ? pos1_ff - start_ff : '0;
   assign ffpos      = (pos_ff != '0) ? pos_ff - OFF_ONE : '0;
   assign close_size = (ffpos > start_ff) ? ffpos - start_ff : '0;
   assign seen2      = (pos1_ff > ffpos) ? pos1_ff - ffpos : '0;
   assign len        = {skip_ff[7:0], data_byte_i};
   assign hdr_len    = 17'd2 + {1'b0, len};
   assign skip_dec   = (skip_ff != '0) ? skip_ff - 17'd1 : skip_ff;
   assign new_marker = {jms_pkg::BYTE_FF, data_byte_i};

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      pos1_in   = pos1_ff;
      start_in  = start_ff;
      marker_in = marker_ff;
      hdr_in    = hdr_ff;
      skip_in   = skip_ff;
      emit_a    = 1'b0;
      emit_b    = 1'b0;
      rec_a     = '0;
      rec_b     = '0;

      if (accept_i) begin
         case (phase_ff)
            PH_M1: begin
               marker_in = {data_byte_i, 8'h00};
               phase_in  = PH_M2;
               emit_a    = end_of_data_i;
               rec_a     = jms_pkg::make_rec(64'(start_ff), 64'(seen),
                                             {data_byte_i, 8'h00}, 1'b1);
            end
            PH_M2: begin
               marker_in = {marker_ff[15:8], data_byte_i};
               emit_a    = end_of_data_i;
               if (marker_ff[15:8] == jms_pkg::BYTE_FF) begin
                  if (jms_pkg::is_soi_eoi({marker_ff[15:8], data_byte_i})) begin
                     hdr_in   = 17'd2;
                     phase_in = PH_SCAN;
                     rec_a    = jms_pkg::make_rec(64'(start_ff), 64'(seen),
                                   {marker_ff[15:8], data_byte_i}, 1'b0);
                  end else begin
                     phase_in = PH_LEN_HI;
                     rec_a    = jms_pkg::make_rec(64'(start_ff), 64'(seen),
                                   {marker_ff[15:8], data_byte_i}, 1'b1);
                  end
               end else begin
                  // no marker at the head: headerless segment, scan at once
                  hdr_in   = '0;
                  phase_in = (data_byte_i == jms_pkg::BYTE_FF) ? PH_SCAN_FF : PH_SCAN;
                  rec_a    = jms_pkg::make_rec(64'(start_ff), 64'(seen),
                                {marker_ff[15:8], data_byte_i}, 1'b0);
               end
            end
            PH_LEN_HI: begin
               skip_in  = {9'h0, data_byte_i};
               phase_in = PH_LEN_LO;
               emit_a   = end_of_data_i;
               rec_a    = jms_pkg::make_rec(64'(start_ff), 64'(seen), marker_ff, 1'b1);
            end
            PH_LEN_LO: begin
               hdr_in = hdr_len;
               if (len > 16'd2) begin
                  skip_in  = {1'b0, len - 16'd2};
                  phase_in = PH_PAYLOAD;
               end else begin
                  skip_in  = '0;
                  phase_in = PH_SCAN;
               end
               emit_a = end_of_data_i;
               rec_a  = jms_pkg::make_rec(64'(start_ff),
                           (64'(hdr_len) > 64'(seen)) ? 64'(hdr_len) : 64'(seen),
                           marker_ff, 1'b0);
            end
            PH_PAYLOAD: begin
               skip_in = skip_dec;
               if (skip_dec == '0) begin
                  phase_in = PH_SCAN;
               end
               emit_a = end_of_data_i;
               rec_a  = jms_pkg::make_rec(64'(start_ff), 64'(hdr_ff), marker_ff, 1'b0);
            end
            PH_SCAN: begin
               phase_in = (data_byte_i == jms_pkg::BYTE_FF) ? PH_SCAN_FF : PH_SCAN;
               emit_a   = end_of_data_i;
               rec_a    = jms_pkg::make_rec(64'(start_ff), 64'(seen), marker_ff, 1'b0);
            end
            default: begin
               // previous byte was FF: fill, stuffing, restart or a real marker
               if (data_byte_i == jms_pkg::BYTE_FF) begin
                  phase_in = PH_SCAN_FF;
                  emit_a   = end_of_data_i;
                  rec_a    = jms_pkg::make_rec(64'(start_ff), 64'(seen), marker_ff, 1'b0);
               end else if (data_byte_i inside {jms_pkg::BYTE_STUFF,
                                               [jms_pkg::RST_FIRST:jms_pkg::RST_LAST]}) begin
                  phase_in = PH_SCAN;
                  emit_a   = end_of_data_i;
                  rec_a    = jms_pkg::make_rec(64'(start_ff), 64'(seen), marker_ff, 1'b0);
               end else begin
                  // close the old segment just before the FF, open the new one on it
                  emit_a    = 1'b1;
                  rec_a     = jms_pkg::make_rec(64'(start_ff), 64'(close_size),
                                                marker_ff, 1'b0);
                  start_in  = ffpos;
                  marker_in = new_marker;
                  emit_b    = end_of_data_i;
                  if (jms_pkg::is_soi_eoi(new_marker)) begin
                     hdr_in   = 17'd2;
                     phase_in = PH_SCAN;
                     rec_b    = jms_pkg::make_rec(64'(ffpos), 64'(seen2), new_marker, 1'b0);
                  end else begin
                     phase_in = PH_LEN_HI;
                     rec_b    = jms_pkg::make_rec(64'(ffpos), 64'(seen2), new_marker, 1'b1);
                  end
               end
            end
         endcase

         // advance the byte offset, saturating
         pos_in  = pos1_ff;
         pos1_in = (pos1_ff == OFF_MAX) ? pos1_ff : pos1_ff + OFF_ONE;

         // end of file: drop everything back to the reset state
         if (end_of_data_i) begin
            phase_in  = PH_M1;
            pos_in    = '0;
            pos1_in   = OFF_ONE;
            start_in  = '0;
            marker_in = '0;
            hdr_in    = '0;
            skip_in   = '0;
         end
      end

      if (emit_b) begin
         rec_b.last_of_run = 1'b1;
      end else begin
         rec_a.last_of_run = 1'b1;
      end
   end

   assign push_o.count = {1'b0, emit_a} + {1'b0, emit_b};
   assign push_o.rec_a = rec_a;
   assign push_o.rec_b = rec_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_M1;
         pos_ff    <= '0;
         pos1_ff   <= OFF_ONE;
         start_ff  <= '0;
         marker_ff <= '0;
         hdr_ff    <= '0;
         skip_ff   <= '0;
      end else begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         pos1_ff   <= pos1_in;
         start_ff  <= start_in;
         marker_ff <= marker_in;
         hdr_ff    <= hdr_in;
         skip_ff   <= skip_in;
      end
   end

   a_two_only_at_end: assert property (@(posedge clock) disable iff (reset)
      push_o.count == 2'd2 |-> (accept_i && end_of_data_i))
      else $error("two records from a byte that is not the last");

   a_push_needs_accept: assert property (@(posedge clock) disable iff (reset)
      push_o.count != 2'd0 |-> accept_i)
      else $error("record produced without an accepted byte");

   a_restart_after_end: assert property (@(posedge clock) disable iff (reset)
      (accept_i && end_of_data_i) |=> (phase_ff == PH_M1 && pos_ff == '0 && start_ff == '0))
      else $error("state not returned to file start after last byte");

endmodule

### src/jms_rsp_queue.sv
// jms_rsp_queue: three-entry shift queue holding records for the result channel.
// Depends on jms_pkg.
module jms_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  jms_pkg::push_type push_i,
   output logic              in_ready_o,
   output logic              rsp_valid_o,
   input  logic              rsp_ready_i,
   output jms_pkg::rec_type  rsp_rec_o
);

   jms_pkg::rec_type q_ff [3];
   jms_pkg::rec_type q_in [3];
   logic [1:0]       cnt_ff, cnt_in;
   logic [1:0]       base;
   logic             pop;

   assign pop         = (cnt_ff != 2'd0) && rsp_ready_i;
   assign base        = cnt_ff - {1'b0, pop};
   assign cnt_in      = base + push_i.count;
   assign in_ready_o  = (cnt_ff <= 2'd1);
   assign rsp_valid_o = (cnt_ff != 2'd0);
   assign rsp_rec_o   = q_ff[0];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         q_in[i] = (pop && i < 2) ? q_ff[(i + 1) % 3] : q_ff[i];
      end
      for (int i = 0; i < 3; i++) begin
         if (push_i.count != 2'd0 && {1'b0, base} == 3'(i)) begin
            q_in[i] = push_i.rec_a;
         end
         if (push_i.count == 2'd2 && ({1'b0, base} + 3'd1) == 3'(i)) begin
            q_in[i] = push_i.rec_b;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_i.count != 2'd0 |-> cnt_ff <= 2'd1)
      else $error("records pushed into a queue without room for two");

   a_pop_decrements: assert property (@(posedge clock) disable iff (reset)
      (pop && push_i.count == 2'd0) |=> cnt_ff == $past(cnt_ff) - 2'd1)
      else $error("queue count did not drop after a pop");

   a_head_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_o && !rsp_ready_i) |=> (rsp_valid_o && $stable(rsp_rec_o)))
      else $error("head record changed while the receiver stalled");

endmodule

### src/jpeg_marker_segmenter.sv
// jpeg_marker_segmenter: top level of the JPEG marker segment scanner.
// Depends on jms_pkg, jms_req_if, jms_rsp_if, jms_parser and jms_rsp_queue.
//
// Usage:
//  - req_chan carries the file one byte per word (data_byte), with
//    end_of_data high on the last byte. A word is taken when valid and
//    ready are both high at a rising clock edge.
//  - rsp_chan delivers segment records: offset, size, marker code, a
//    truncated flag and last_of_run on the final record caused by a byte.
//    A byte causes no record, one record (a closed segment, or the last
//    segment at end of file) or two (marker on the last byte).
//  - A record is written into the queue register when its byte is
//    accepted and is shown on rsp_chan once earlier records are taken.
//    One byte per cycle while ready is high, each a single registered parser step.
//  - Records wait in a three-entry queue. req_chan.ready is high while at
//    most one record waits, so a stalled receiver holds the block only
//    once two records are pending; nothing is dropped.
//  - Reset (synchronous, active high) empties the queue and returns the
//    parser to offset zero, expecting the first marker byte. After a
//    byte with end_of_data the next byte starts a new file at offset zero.
//  - Byte offsets saturate at 2^OFFSET_BITS - 1; reported offsets and
//    sizes saturate at 32 bits.
module jpeg_marker_segmenter #(
   parameter int OFFSET_BITS = jms_pkg::OFFSET_BITS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   jms_req_if.sink  req_chan,
   jms_rsp_if.source rsp_chan
);

   logic              req_accept;
   logic              queue_ready;
   jms_pkg::push_type push;
   jms_pkg::rec_type  head_rec;

   // take a byte whenever the queue has room for the worst case of two records
   assign req_chan.ready = queue_ready;
   assign req_accept     = req_chan.valid && queue_ready;

   jms_parser #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .accept_i      (req_accept),
      .data_byte_i   (req_chan.data_byte),
      .end_of_data_i (req_chan.end_of_data),
      .push_o        (push)
   );

   jms_rsp_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_i      (push),
      .in_ready_o  (queue_ready),
      .rsp_valid_o (rsp_chan.valid),
      .rsp_ready_i (rsp_chan.ready),
      .rsp_rec_o   (head_rec)
   );

   // unpack the head record onto the result channel
   assign rsp_chan.segment_offset = head_rec.segment_offset;
   assign rsp_chan.segment_size   = head_rec.segment_size;
   assign rsp_chan.marker_code    = head_rec.marker_code;
   assign rsp_chan.truncated      = head_rec.truncated;
   assign rsp_chan.last_of_run    = head_rec.last_of_run;

endmodule

### verif/jms_segment_checker.sv
// jms_segment_checker: watches the byte and record channels of the JPEG marker
// segmenter, predicts each segment record and compares it field by field.
// Depends on jms_pkg, jms_req_if and jms_rsp_if.
module jms_segment_checker (
   input  logic clock,
   input  logic reset,
   jms_req_if   req_mon,
   jms_rsp_if   rsp_mon,
   output int   mismatches,
   output int   records_waiting
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [6:0] {
      PH_MARK_HI = 7'b0000001,
      PH_MARK_LO = 7'b0000010,
      PH_LEN_HI  = 7'b0000100,
      PH_LEN_LO  = 7'b0001000,
      PH_PAYLOAD = 7'b0010000,
      PH_SCAN    = 7'b0100000,
      PH_SCAN_FF = 7'b1000000
   } scan_phase_type;

   // Byte offsets saturate at 2^OFFSET_BITS - 1, with OFFSET_BITS at its default.
   localparam logic [63:0] POS_MAX = (64'd1 << jms_pkg::OFFSET_BITS_DEF) - 64'd1;

   scan_phase_type phase;
   logic [63:0] byte_pos;
   logic [63:0] seg_start;
   logic [15:0] marker;
   logic [16:0] hdr_size;
   logic [16:0] skip_cnt;

   jms_pkg::rec_type records_due[$];
   int      error_count = 0;

   function automatic logic [63:0] bump(logic [63:0] x);
      return (x >= POS_MAX) ? POS_MAX : x + 64'd1;
   endfunction

   function automatic logic [63:0] gap(logic [63:0] a, logic [63:0] b);
      return (a > b) ? a - b : 64'd0;
   endfunction

   function automatic logic [31:0] sat32(logic [63:0] x);
      return (x > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : x[31:0];
   endfunction

   function automatic logic soi_or_eoi(logic [15:0] w);
      return (w == jms_pkg::MARKER_SOI) || (w == jms_pkg::MARKER_EOI);
   endfunction

   task automatic clear_scan();
      phase     = PH_MARK_HI;
      byte_pos  = '0;
      seg_start = '0;
      marker    = '0;
      hdr_size  = '0;
      skip_cnt  = '0;
   endtask

   task automatic add_rec(input logic [63:0] start, input logic [63:0] size,
                          input logic [15:0] code, input logic trunc, input logic is_last);
      jms_pkg::rec_type r;
      r.segment_offset = sat32(start);
      r.segment_size   = sat32(size);
      r.marker_code    = code;
      r.truncated      = trunc;
      r.last_of_run    = is_last;
      records_due.push_back(r);
   endtask

   // Advance the scanner by one byte and queue the records it closes.
   task automatic scan_byte(input logic [7:0] b, input logic last_byte);
      logic [63:0] pos;
      logic [63:0] seen;
      logic [63:0] ffpos;
      logic [63:0] seen2;
      logic [15:0] seg_len;
      pos  = byte_pos;
      seen = gap(bump(pos), seg_start);
      case (phase)
         PH_MARK_HI: begin
            marker = {b, 8'h00};
            phase  = PH_MARK_LO;
            if (last_byte) add_rec(seg_start, seen, marker, 1'b1, 1'b1);
         end
         PH_MARK_LO: begin
            marker[7:0] = b;
            if (marker[15:8] == jms_pkg::BYTE_FF) begin
               if (soi_or_eoi(marker)) begin
                  hdr_size = 17'd2;
                  phase    = PH_SCAN;
                  if (last_byte) add_rec(seg_start, seen, marker, 1'b0, 1'b1);
               end else begin
                  phase = PH_LEN_HI;
                  if (last_byte) add_rec(seg_start, seen, marker, 1'b1, 1'b1);
               end
            end else begin
               // no marker at the head: headerless segment, scan right away
               hdr_size = '0;
               phase    = (b == jms_pkg::BYTE_FF) ? PH_SCAN_FF : PH_SCAN;
               if (last_byte) add_rec(seg_start, seen, marker, 1'b0, 1'b1);
            end
         end
         PH_LEN_HI: begin
            skip_cnt = {9'd0, b};
            phase    = PH_LEN_LO;
            if (last_byte) add_rec(seg_start, seen, marker, 1'b1, 1'b1);
         end
         PH_LEN_LO: begin
            seg_len  = {skip_cnt[7:0], b};
            hdr_size = 17'd2 + {1'b0, seg_len};
            // a length below 3 leaves no payload to skip
            if (seg_len > 16'd2) begin
               skip_cnt = {1'b0, seg_len} - 17'd2;
               phase    = PH_PAYLOAD;
            end else begin
               skip_cnt = '0;
               phase    = PH_SCAN;
            end
            if (last_byte)
               add_rec(seg_start, ({47'd0, hdr_size} > seen) ? {47'd0, hdr_size} : seen,
                       marker, 1'b0, 1'b1);
         end
         PH_PAYLOAD: begin
            if (skip_cnt != 0) skip_cnt = skip_cnt - 17'd1;
            if (skip_cnt == 0) phase = PH_SCAN;
            // ending inside the payload reports the declared size
            if (last_byte) add_rec(seg_start, {47'd0, hdr_size}, marker, 1'b0, 1'b1);
         end
         PH_SCAN: begin
            phase = (b == jms_pkg::BYTE_FF) ? PH_SCAN_FF : PH_SCAN;
            if (last_byte) add_rec(seg_start, seen, marker, 1'b0, 1'b1);
         end
         default: begin
            if (b == jms_pkg::BYTE_FF) begin
               phase = PH_SCAN_FF;
               if (last_byte) add_rec(seg_start, seen, marker, 1'b0, 1'b1);
            end else if (b == jms_pkg::BYTE_STUFF ||
                         (b >= jms_pkg::RST_FIRST && b <= jms_pkg::RST_LAST)) begin
               phase = PH_SCAN;
               if (last_byte) add_rec(seg_start, seen, marker, 1'b0, 1'b1);
            end else begin
               // real marker: close the old segment at its FF byte, open the new one
               ffpos = gap(pos, 64'd1);
               add_rec(seg_start, gap(ffpos, seg_start), marker, 1'b0, !last_byte);
               seg_start = ffpos;
               marker    = {jms_pkg::BYTE_FF, b};
               seen2     = gap(bump(pos), seg_start);
               if (soi_or_eoi(marker)) begin
                  hdr_size = 17'd2;
                  phase    = PH_SCAN;
                  if (last_byte) add_rec(seg_start, seen2, marker, 1'b0, 1'b1);
               end else begin
                  phase = PH_LEN_HI;
                  if (last_byte) add_rec(seg_start, seen2, marker, 1'b1, 1'b1);
               end
            end
         end
      endcase
      byte_pos = bump(pos);
      if (last_byte) clear_scan();
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h, got %h", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      jms_pkg::rec_type want;
      if (reset) begin
         clear_scan();
         records_due.delete();
      end else begin
         if (req_mon.valid && req_mon.ready)
            scan_byte(req_mon.data_byte, req_mon.end_of_data);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (records_due.size() == 0) begin
               $display("%0t: record word with none expected: offset %h size %h marker %h",
                        $time, rsp_mon.segment_offset, rsp_mon.segment_size,
                        rsp_mon.marker_code);
               error_count++;
            end else begin
               want = records_due.pop_front();
               check_field("segment_offset", want.segment_offset, rsp_mon.segment_offset);
               check_field("segment_size", want.segment_size, rsp_mon.segment_size);
               check_field("marker_code", {16'd0, want.marker_code},
                           {16'd0, rsp_mon.marker_code});
               check_field("truncated", {31'd0, want.truncated}, {31'd0, rsp_mon.truncated});
               check_field("last_of_run", {31'd0, want.last_of_run},
                           {31'd0, rsp_mon.last_of_run});
            end
         end
      end
      mismatches      <= error_count;
      records_waiting <= records_due.size();
   end

endmodule

### verif/testbench.sv
// testbench: drives JPEG-like byte files into jpeg_marker_segmenter and gives
// the verdict; prediction and comparison live in jms_segment_checker.
// Depends on jms_pkg, jms_req_if, jms_rsp_if and the block itself.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // Longest correct quiet stretch is a run of random stalls with p <= 0.57
   // per cycle, or the short tail at the end; this is far above either.
   localparam int QUIET_LIMIT = 2000;

   logic clock;
   logic reset;

   jms_req_if req_chan ();
   jms_rsp_if rsp_chan ();

   int fail_count;
   int pending;
   int quiet_cycles = 0;
   int src_idle_pct = 0;
   int sink_idle_pct = 0;
   int bytes_sent = 0;

   logic [7:0] file_bytes[$];

   jpeg_marker_segmenter DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   jms_segment_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .mismatches      (fail_count),
      .records_waiting (pending)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Stall the record receiver at random, at the rate of the current phase.
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
   end

   // Count cycles in which no word moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("jpeg_marker_segmenter: mismatch");
      $finish;
   end

   // Offer one byte word, with random gaps ahead of it; hold it until taken.
   task automatic send_byte(input logic [7:0] b, input logic is_last);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.data_byte   <= b;
      req_chan.end_of_data <= is_last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      bytes_sent++;
   endtask

   // Send the whole file held in file_bytes; flag its last byte as end of data.
   task automatic send_file();
      for (int i = 0; i < file_bytes.size(); i++)
         send_byte(file_bytes[i], i == file_bytes.size() - 1);
   endtask

   // Drop valid and hold until every predicted record has come out.
   task automatic drain_records();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic push_random(input int count, input int ff_odds);
      repeat (count)
         file_bytes.push_back(($urandom_range(0, 99) < ff_odds) ?
                              jms_pkg::BYTE_FF : 8'($urandom_range(0, 255)));
   endtask

   // Build one random file. Most are well formed (SOI, length segments,
   // entropy data with stuffing, restarts and fill, EOI), some cut short,
   // the rest noise, huge declared lengths or a missing FF at the head.
   task automatic build_file();
      int kind;
      int nseg;
      int nscan;
      int keep;
      logic [7:0]  code;
      logic [15:0] seg_len;
      file_bytes.delete();
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
         file_bytes.push_back(jms_pkg::BYTE_FF);
         file_bytes.push_back(jms_pkg::MARKER_SOI[7:0]);
         nseg = $urandom_range(0, 3);
         repeat (nseg) begin
            code = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 8'hBF))
                                               : 8'($urandom_range(8'hC0, 8'hFE));
            if (code >= jms_pkg::RST_FIRST && code <= jms_pkg::RST_LAST) code = 8'hDB;
            file_bytes.push_back(jms_pkg::BYTE_FF);
            file_bytes.push_back(code);
            if (!({jms_pkg::BYTE_FF, code} == jms_pkg::MARKER_SOI ||
                  {jms_pkg::BYTE_FF, code} == jms_pkg::MARKER_EOI)) begin
               seg_len = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(21, 300))
                                                      : 16'($urandom_range(0, 20));
               file_bytes.push_back(seg_len[15:8]);
               file_bytes.push_back(seg_len[7:0]);
               if (seg_len > 16'd2) push_random(seg_len - 2, 10);
            end
            nscan = $urandom_range(0, 6);
            repeat (nscan) begin
               case ($urandom_range(0, 5))
                  3: begin
                     file_bytes.push_back(jms_pkg::BYTE_FF);
                     file_bytes.push_back(jms_pkg::BYTE_STUFF);
                  end
                  4: begin
                     file_bytes.push_back(jms_pkg::BYTE_FF);
                     file_bytes.push_back(jms_pkg::RST_FIRST + 8'($urandom_range(0, 7)));
                  end
                  5: begin
                     file_bytes.push_back(jms_pkg::BYTE_FF);
                     file_bytes.push_back(jms_pkg::BYTE_FF);
                  end
                  default: file_bytes.push_back(8'($urandom_range(0, 8'hFE)));
               endcase
            end
         end
         file_bytes.push_back(jms_pkg::BYTE_FF);
         file_bytes.push_back(jms_pkg::MARKER_EOI[7:0]);
         // cut some files short anywhere, headers included
         if ($urandom_range(0, 3) == 0) begin
            keep = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > keep) void'(file_bytes.pop_back());
         end
      end else if (kind == 7) begin
         push_random($urandom_range(1, 24), 30);
      end else if (kind == 8) begin
         file_bytes.push_back(jms_pkg::BYTE_FF);
         push_random(3, 0);
         push_random($urandom_range(0, 6), 20);
      end else begin
         file_bytes.push_back(8'($urandom_range(0, 8'hFE)));
         push_random($urandom_range(0, 10), 25);
      end
   endtask

   initial begin
      int phase_start;
      reset                = 1'b1;
      rsp_chan.ready       = 1'b0;
      req_chan.valid       = 1'b0;
      req_chan.data_byte   = 8'h00;
      req_chan.end_of_data = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < 3; ph++) begin
         // receiver-heavy gaps first, then sender-heavy, then full rate
         src_idle_pct  = (ph == 0) ? 38 : (ph == 1) ? 57 : 0;
         sink_idle_pct <= (ph == 0) ? 57 : (ph == 1) ? 38 : 0;
         phase_start = bytes_sent;
         if (ph == 0) begin
            // single byte: truncated marker
            file_bytes = '{8'hFF};
            send_file();
            // SOI alone: complete header
            file_bytes = '{8'hFF, 8'hD8};
            send_file();
            // end inside the length field
            file_bytes = '{8'hFF, 8'hE1, 8'h00};
            send_file();
            // full length 0xFFFF, end inside payload
            file_bytes = '{8'hFF, 8'hDB, 8'hFF, 8'hFF, 8'h12};
            send_file();
            // tiny length, stuffing, restart, fill, EOI on the last byte
            file_bytes = '{8'hFF, 8'hD8, 8'hFF, 8'hE0, 8'h00, 8'h01, 8'hAB, 8'hFF,
                           8'h00, 8'hFF, 8'hD5, 8'hFF, 8'hFF, 8'hFF, 8'hD9};
            send_file();
            // no FF at the head, then a lone FF; then a length marker last
            file_bytes = '{8'h7F, 8'hFF, 8'hC4};
            send_file();
            drain_records();
         end
         while (bytes_sent - phase_start < 500) begin
            build_file();
            send_file();
         end
         drain_records();
      end

      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("jpeg_marker_segmenter: match");
      else
         $display("jpeg_marker_segmenter: mismatch");
      $finish;
   end

endmodule

### jpeg_marker_segmenter.f
src/jms_pkg.sv
src/jms_req_if.sv
src/jms_rsp_if.sv
src/jms_parser.sv
src/jms_rsp_queue.sv
src/jpeg_marker_segmenter.sv
verif/jms_segment_checker.sv
verif/testbench.sv
